[sv/md5_hash_engine_core_macros.svh]
// Assertion macros for the MD5 engine checker.
`ifndef MD5_HASH_ENGINE_CORE_MACROS_SVH
`define MD5_HASH_ENGINE_CORE_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define MD5_ASSERT_IMP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that a signal group holds while a stalled word waits.
`define MD5_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    cond |=> $stable(sig)) else $error(msg);
`endif

[sv/md5_pkg.sv]
// Package with MD5 constants, opcodes, states and the per-round table functions.
package md5_pkg;
  typedef enum logic [1:0] {
    OP_ABSORB  = 2'd0,
    OP_DIGEST  = 2'd1,
    OP_RESTART = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_OUT
  } state_e;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // Control handed from the sequencer to the round unit.
  typedef struct packed {
    logic       start;    // load working vars from chain words
    logic       step;     // run one round
    logic [5:0] round;
  } rnd_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    begin
      case ({i[5:4], i[1:0]})
        4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
        4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
        4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // Message word index used by a round.
  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    logic [3:0] l;
    begin
      l = i[3:0];
      case (i[5:4])
        2'd0: g = l;
        2'd1: g = 4'((l << 2) + l + 4'd1);
        2'd2: g = 4'((l << 1) + l + 4'd5);
        default: g = 4'((l << 3) - l);
      endcase
      return g;
    end
  endfunction
endpackage

[sv/md5_rounds.sv]
// MD5 compression datapath: one round per cycle while step is set.
module md5_rounds import md5_pkg::*; (
  input  logic         clk_i,
  input  rnd_ctl_t     ctl_i,
  input  logic [127:0] cv_i,
  input  logic [31:0]  m_i,
  output logic [127:0] sum_o
);
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] f, t, r, k;
  logic [4:0]  s;

  // Form one round result.
  always_comb begin
    case (ctl_i.round[5:4])
      2'd0: f = d_q ^ (b_q & (c_q ^ d_q));
      2'd1: f = c_q ^ (d_q & (b_q ^ c_q));
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    k = round_k(ctl_i.round);
    s = round_s(ctl_i.round);
    t = a_q + f + k + m_i;
    r = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  // Load or advance the working words.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q <= cv_i[31:0];
      b_q <= cv_i[63:32];
      c_q <= cv_i[95:64];
      d_q <= cv_i[127:96];
    end else if (ctl_i.step) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + r;
    end
  end

  assign sum_o = {cv_i[127:96] + d_q, cv_i[95:64] + c_q,
                  cv_i[63:32] + b_q, cv_i[31:0] + a_q};
endmodule

[sv/md5_hash_engine_core.sv]
// MD5 engine top level: byte buffer memory, sequencer and output register.
// Usage: send words on the input channel (operation_i, data_byte_i with
// valid/ready). Absorb appends a byte, digest returns one output word with
// the 16-byte digest, restart reloads the initial chain value and clears the count.
// Absorb writes the byte into the 16-entry word memory; the 64th byte of a
// block then starts a compression (one round per cycle through the round
// unit, message words read from the memory through a registered read).
// Digest pads the pending block on the fly as its words are read, over one
// final block or two, then the word waits in the output register.
// Reset clears the count and loads the initial chain value; the buffer
// memory keeps its contents and needs no clearing. While the receiver
// stalls the digest word holds and no new input word is taken.
// Digest leaves the chain value, count and buffer untouched, so absorbing may continue.
module md5_hash_engine_core import md5_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_low_o,
  output logic [63:0] digest_high_o
);
  state_e state_q, state_d;
  logic [127:0] cv_q, cv_d, wcv_q, wcv_d;
  logic [63:0]  cnt_q, cnt_d;
  logic [31:0]  mem [16];
  logic [31:0]  rd_q;
  logic [3:0]   ra_q;          // word address held in rd_q
  logic [31:0]  pad_word;
  logic [127:0] sum;
  logic [6:0]   ph_q, ph_d;    // round counter incl. lead-in
  logic         dig_q, dig_d;  // compression belongs to a digest
  logic         fin_q, fin_d;  // last pad block in progress
  logic         two_q, two_d;  // second pad block pending
  logic         we;
  logic [3:0]   wa, ra;
  logic [31:0]  wd;
  logic [5:0]   fill;
  logic [5:0]   bi;
  rnd_ctl_t     ctl;
  logic         out_ld;

  assign fill = cnt_q[8:3];

  // Message words of the pad block built from memory word, fill and count.
  always_comb begin
    pad_word = 32'd0;
    for (int j = 0; j < 4; j++) begin
      bi = {ra_q, 2'(j)};
      if (two_q) pad_word[8*j +: 8] = 8'd0;
      else if (bi < fill) pad_word[8*j +: 8] = rd_q[8*j +: 8];
      else if (bi == fill) pad_word[8*j +: 8] = PAD_BYTE;
      if (fin_q && bi >= 6'd56) pad_word[8*j +: 8] = cnt_q[8*(32'(bi) - 56) +: 8];
    end
  end

  // Byte lane write into a word of the memory.
  always_comb begin
    wd = rd_q;
    wd[8*fill[1:0] +: 8] = data_byte_i;
  end

  // Read the word memory; write the patched word back, forward it on a hit.
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (we && wa == ra) rd_q <= wd;
    else rd_q <= mem[ra];
    ra_q <= ra;
  end

  md5_rounds u_rounds (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .cv_i  (wcv_q),
    .m_i   ((state_q == ST_PAD) ? pad_word : rd_q),
    .sum_o (sum)
  );

  // Sequence absorb, compression and padding.
  always_comb begin
    state_d = state_q;
    cv_d = cv_q; wcv_d = wcv_q; cnt_d = cnt_q; ph_d = ph_q;
    dig_d = dig_q; fin_d = fin_q; two_d = two_q;
    in_ready_o = 1'b0; we = 1'b0; wa = fill[5:2];
    ra = fill[5:2]; out_ld = 1'b0;
    ctl = '0;
    ctl.round = 6'(ph_q - 7'd1);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (operation_i)
            OP_ABSORB: begin
              // rd_q holds the word at fill (read ahead last cycle)
              we = 1'b1;
              cnt_d = cnt_q + 64'd8;
              ra = cnt_d[8:5];
              if (fill == 6'd63) begin
                state_d = ST_COMP; ph_d = '0; dig_d = 1'b0; wcv_d = cv_q;
                ra = 4'd0;
              end
            end
            OP_DIGEST: begin
              state_d = ST_COMP; ph_d = '0; dig_d = 1'b1; wcv_d = cv_q;
              fin_d = (fill < 6'd56); two_d = 1'b0; ra = 4'd0;
            end
            OP_RESTART: begin
              cv_d = {IV3, IV2, IV1, IV0}; cnt_d = '0; ra = 4'd0;
            end
            default: ;
          endcase
        end
      end
      ST_COMP, ST_PAD: begin
        // lead-in loads words, then 64 rounds, then a closing step takes the sums
        ra = round_g(6'(ph_q));
        if (ph_q == 7'd0) ctl.start = 1'b1;
        else ctl.step = 1'b1;
        if (dig_q) state_d = ST_PAD;
        ph_d = ph_q + 7'd1;
        if (ph_q == 7'd64) begin
          ph_d = 7'd65;
        end
        if (ph_q == 7'd65) begin
          ctl = '0;
          ph_d = '0;
          if (!dig_q) begin
            cv_d = sum; state_d = ST_IDLE; ra = fill[5:2];
          end else if (!fin_q) begin
            wcv_d = sum; fin_d = 1'b1; two_d = 1'b1; ra = 4'd0;
          end else begin
            out_ld = 1'b1; state_d = ST_OUT; wcv_d = sum;
          end
        end
      end
      ST_OUT: begin
        ra = fill[5:2];
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cv_q <= {IV3, IV2, IV1, IV0};
      cnt_q <= '0;
      ph_q <= '0;
      dig_q <= 1'b0; fin_q <= 1'b0; two_q <= 1'b0;
    end else begin
      state_q <= state_d; cv_q <= cv_d; cnt_q <= cnt_d; ph_q <= ph_d;
      dig_q <= dig_d; fin_q <= fin_d; two_q <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wcv_q <= wcv_d;
    if (out_ld) begin
      digest_low_o  <= sum[63:0];
      digest_high_o <= sum[127:64];
    end
  end

  assign out_valid_o = (state_q == ST_OUT);
endmodule

[sv/md5_hash_engine_core_chk.sv]
// Port-level checker for the MD5 engine, bound to the top level.
`include "md5_hash_engine_core_macros.svh"
module md5_hash_engine_core_chk import md5_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  operation_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] digest_low_o,
  input logic [63:0] digest_high_o
);
  `MD5_ASSERT_HOLD(a_hold_lo, clk_i, rst_ni, out_valid_o && !out_ready_i, digest_low_o, "low moved")
  `MD5_ASSERT_HOLD(a_hold_hi, clk_i, rst_ni, out_valid_o && !out_ready_i, digest_high_o, "high moved")
  `MD5_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_o |-> !in_ready_o, "input taken during output")
  `MD5_ASSERT_IMP(a_dig_nores, clk_i, rst_ni, (in_valid_i && in_ready_o && operation_i == OP_DIGEST) |=> !out_valid_o, "digest too early")
endmodule

bind md5_hash_engine_core md5_hash_engine_core_chk u_chk (.*);
